// File: sv/ttc_emergency_brake_assert.svh
// ----------------------------------------------------------------------------
// ttc_emergency_brake assertion macros
// Same-cycle and next-cycle implication checks on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TTC_EMERGENCY_BRAKE_ASSERT_SVH
`define TTC_EMERGENCY_BRAKE_ASSERT_SVH

// check cons in the same cycle as ante
`define TEB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttc_emergency_brake: same-cycle check failed");

// check cons in the cycle after ante
`define TEB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttc_emergency_brake: next-cycle check failed");

`endif

// File: sv/ttc_eb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_eb_pkg
// Shared constants, types and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package ttc_eb_pkg;

  localparam int COS_TABLE_ENTRIES = 1024;
  localparam int IDX_W             = $clog2(COS_TABLE_ENTRIES);
  localparam int FIDX_W            = IDX_W - 1;
  localparam int COS_QTR           = COS_TABLE_ENTRIES / 4;
  localparam int ANGLE_PER_ENTRY   = 65536 / COS_TABLE_ENTRIES;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic [15:0] NO_RETURN   = 16'hFFFF;
  localparam logic [9:0]  RANGE_SCALE = 10'd1000;

  localparam logic [15:0] THRESHOLD_RESET  = 16'd1000;
  localparam logic [15:0] START_ANGLE_RST  = 16'd0;
  localparam logic [15:0] ANGLE_STEP_RESET = 16'd182;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [7:0] {
    CFG_THRESHOLD   = 8'd0,
    CFG_START_ANGLE = 8'd1,
    CFG_ANGLE_STEP  = 8'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_SPEED = 1'b0,
    CMD_BEAM  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                command;
    logic                last;
    logic                first;
    logic signed [15:0]  speed;
    logic [15:0]         range;
    logic [FIDX_W-1:0]   fidx;
    logic                neg;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } fifo_status_t;

  typedef logic [14:0] qtab_t [COS_QTR];

  // restoring long division, evaluated only while building the cosine constants
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [14:0] quad_cos(input logic [16:0] x);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    longint          q;
    theta = (longint'(x) * PI_Q30) >> 15;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = longint'(term);
    for (int k = 1; k <= 8; k++) begin
      term = div_u64((term * t2) >> 30, 64'((2 * k - 1) * (2 * k)));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return q[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < COS_QTR; i++) begin
      t[i] = quad_cos(17'(i * ANGLE_PER_ENTRY));
    end
    return t;
  endfunction

  localparam qtab_t       COS_QTAB = build_qtab();
  localparam logic [14:0] COS_QEND = quad_cos(17'd16384);

endpackage

// File: sv/ttc_eb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_eb_front
// Accepts words, tracks the scan angle and folds it to a quarter-wave index.
// ----------------------------------------------------------------------------
module ttc_eb_front import ttc_eb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         s_axis_tuser,
  input  logic         full_i,
  input  logic [15:0]  start_angle_i,
  input  logic [15:0]  angle_step_i,
  output logic         push_o,
  output q_entry_t     entry_o
);

  logic [15:0]       angle_q, angle_d;
  logic              scan_start_q, scan_start_d;
  logic [15:0]       angle;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        quad;
  logic [IDX_W-3:0]  low;
  logic              low_zero;
  logic [FIDX_W-1:0] low_ext;
  logic [FIDX_W-1:0] mirror;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  assign angle    = scan_start_q ? start_angle_i : angle_q;
  assign idx      = angle[15 -: IDX_W];
  assign quad     = idx[IDX_W-1 -: 2];
  assign low      = idx[IDX_W-3:0];
  assign low_zero = (low == '0);
  assign low_ext  = {1'b0, low};
  assign mirror   = FIDX_W'(COS_QTR) - low_ext;

  always_comb begin
    entry_o.command = cmd_e'(s_axis_tuser);
    entry_o.last    = s_axis_tlast;
    entry_o.first   = scan_start_q;
    entry_o.speed   = s_axis_tdata[15:0];
    entry_o.range   = s_axis_tdata[31:16];
    case (quad)
      2'd0: begin
        entry_o.fidx = low_ext;
        entry_o.neg  = 1'b0;
      end
      2'd1: begin
        entry_o.fidx = mirror;
        entry_o.neg  = !low_zero;
      end
      2'd2: begin
        entry_o.fidx = low_ext;
        entry_o.neg  = 1'b1;
      end
      default: begin
        entry_o.fidx = mirror;
        entry_o.neg  = low_zero;
      end
    endcase
  end

  always_comb begin
    angle_d      = angle_q;
    scan_start_d = scan_start_q;
    if (push_o && (cmd_e'(s_axis_tuser) == CMD_BEAM)) begin
      angle_d      = angle + angle_step_i;
      scan_start_d = s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q      <= '0;
      scan_start_q <= 1'b1;
    end else begin
      angle_q      <= angle_d;
      scan_start_q <= scan_start_d;
    end
  end

endmodule

// File: sv/ttc_eb_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_eb_fifo
// Short word queue between the front and the back.
// ----------------------------------------------------------------------------
module ttc_eb_fifo import ttc_eb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  q_entry_t     entry_i,
  input  logic         pop_i,
  output q_entry_t     entry_o,
  output fifo_status_t status_o
);

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: sv/ttc_eb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_eb_back
// Cosine lookup, closing speed, threshold compare and the brake word.
// ----------------------------------------------------------------------------
module ttc_eb_back import ttc_eb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  q_entry_t     entry_i,
  input  logic         empty_i,
  input  logic [15:0]  threshold_i,
  output logic         pop_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata
);

  logic                advance;
  logic                is_beam;
  logic [14:0]         cos_mag;

  logic signed [15:0]  speed_q, speed_d;

  logic                s1_valid_q;
  logic                s1_last_q, s1_first_q, s1_neg_q;
  logic [14:0]         s1_mag_q;
  logic signed [15:0]  s1_speed_q;
  logic [15:0]         s1_range_q;

  logic                s2_valid_q;
  logic                s2_last_q, s2_first_q;
  logic [15:0]         s2_range_q;
  logic [14:0]         s2_close_q;

  logic                s3_valid_q;
  logic                s3_last_q, s3_first_q, s3_ok_q;
  logic [25:0]         s3_lhs_q;
  logic [30:0]         s3_rhs_q;

  logic                out_valid_q, out_valid_d;
  logic                brake_q;
  logic                threat_q, threat_d;

  logic [15:0]         speed_abs;
  logic [29:0]         prod;
  logic                closing_pos;
  logic                hit;
  logic                threat_now;

  assign advance = !out_valid_q || m_axis_tready;
  assign pop_o   = advance && !empty_i;
  assign is_beam = (entry_i.command == CMD_BEAM);

  assign cos_mag = (entry_i.fidx == FIDX_W'(COS_QTR)) ? COS_QEND
                                                       : COS_QTAB[entry_i.fidx[FIDX_W-2:0]];

  assign speed_abs   = s1_speed_q[15] ? 16'(-s1_speed_q) : s1_speed_q;
  assign prod        = 30'({14'b0, speed_abs} * {15'b0, s1_mag_q});
  assign closing_pos = (s1_speed_q != '0) && (s1_mag_q != '0) && (s1_speed_q[15] == s1_neg_q);

  assign hit        = s3_ok_q && (31'(s3_lhs_q) < s3_rhs_q);
  assign threat_now = (s3_first_q ? 1'b0 : threat_q) | hit;

  assign speed_d     = (pop_o && !is_beam) ? entry_i.speed : speed_q;
  assign threat_d    = (advance && s3_valid_q) ? threat_now : threat_q;
  assign out_valid_d = advance ? (s3_valid_q && s3_last_q) : out_valid_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, brake_q};

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q  <= entry_i.last;
      s1_first_q <= entry_i.first;
      s1_neg_q   <= entry_i.neg;
      s1_mag_q   <= cos_mag;
      s1_speed_q <= speed_q;
      s1_range_q <= entry_i.range;

      s2_last_q  <= s1_last_q;
      s2_first_q <= s1_first_q;
      s2_range_q <= s1_range_q;
      s2_close_q <= closing_pos ? prod[29:15] : '0;

      s3_last_q  <= s2_last_q;
      s3_first_q <= s2_first_q;
      s3_ok_q    <= (s2_range_q != NO_RETURN) && (s2_close_q != '0);
      s3_lhs_q   <= {10'b0, s2_range_q} * {16'b0, RANGE_SCALE};
      s3_rhs_q   <= {15'b0, threshold_i} * {16'b0, s2_close_q};

      if (s3_valid_q && s3_last_q) begin
        brake_q <= threat_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      threat_q    <= 1'b0;
    end else begin
      speed_q     <= speed_d;
      threat_q    <= threat_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        s1_valid_q <= pop_o && is_beam;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
      end
    end
  end

endmodule

// File: sv/ttc_emergency_brake.sv
`timescale 1ns / 1ps
// A beam word that closes a scan goes from the queue through s1, s2 and s3 into the output brake register.
// Throughput: one word per cycle while no brake word is held, set by the single queue pop and the output register.
// A held brake word stalls the back pipeline; the front keeps filling the 4-word queue.
// Reset: rst_ni is asynchronous and active low; it empties the queue and pipeline and
// loads the register reset values. The cosine table is constant and needs no fill.
// ----------------------------------------------------------------------------
// ttc_emergency_brake
// Time-to-collision braking decision over lidar scans.
// ----------------------------------------------------------------------------
`include "ttc_emergency_brake_assert.svh"

module ttc_emergency_brake import ttc_eb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // speed_mm_s, range_mm
  input  logic         s_axis_tlast,
  input  logic         s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // brake
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_addr_i,
  input  logic [15:0]  cfg_data_i
);

  logic [15:0]  threshold_q, threshold_d;
  logic [15:0]  start_angle_q, start_angle_d;
  logic [15:0]  angle_step_q, angle_step_d;

  logic         push;
  logic         pop;
  q_entry_t     push_entry;
  q_entry_t     pop_entry;
  fifo_status_t fifo_status;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    threshold_d   = threshold_q;
    start_angle_d = start_angle_q;
    angle_step_d  = angle_step_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD:   threshold_d   = cfg_data_i;
        CFG_START_ANGLE: start_angle_d = cfg_data_i;
        CFG_ANGLE_STEP:  angle_step_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= THRESHOLD_RESET;
      start_angle_q <= START_ANGLE_RST;
      angle_step_q  <= ANGLE_STEP_RESET;
    end else begin
      threshold_q   <= threshold_d;
      start_angle_q <= start_angle_d;
      angle_step_q  <= angle_step_d;
    end
  end

  ttc_eb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (fifo_status.full),
    .start_angle_i (start_angle_q),
    .angle_step_i  (angle_step_q),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  ttc_eb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (fifo_status)
  );

  ttc_eb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .empty_i       (fifo_status.empty),
    .threshold_i   (threshold_q),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `TEB_ASSERT_SAME(a_no_pop_on_stall, m_axis_tvalid && !m_axis_tready, !pop)
  `TEB_ASSERT_SAME(a_pop_not_empty, pop, !fifo_status.empty)
  `TEB_ASSERT_NEXT(a_count_up, push && !pop,
                   fifo_status.count == $past(fifo_status.count) + 1'b1)

endmodule

// File: bench/tb_ttc_emergency_brake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ttc_emergency_brake
// Self-checking bench for the time-to-collision brake. A directed table and
// random lidar scans go through the input stream, and each brake word is
// compared with a table value or a local copy of the scan logic. The reset
// settings, six programmed register sets and several idling mixes are covered.
// ----------------------------------------------------------------------------
module tb_ttc_emergency_brake;
  import ttc_eb_pkg::*;

  localparam int          PHASES        = 6;
  localparam int          PHASE_WORDS   = 125;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int          HOLD_CYCLES   = 300;
  localparam logic [7:0]  CFG_SPARE_IDX = 8'd3;
  localparam int          WANT_MODEL    = -1;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] speed;
    logic [15:0] range_mm;
    logic        last;
    int          want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_BEAM,  16'h0000, 16'h0000, 1'b1, 0},          // zero speed
    '{CMD_SPEED, 16'h7FFF, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'hFFFF, 1'b1, 0},          // no return
    '{CMD_BEAM,  16'h0000, 16'h0000, 1'b1, 1},          // zero range, full speed
    '{CMD_BEAM,  16'h0000, 16'hFFFE, 1'b1, WANT_MODEL},
    '{CMD_SPEED, 16'h8000, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'h0000, 1'b1, 0},          // reversing
    '{CMD_SPEED, 16'hFFFF, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'hFFFF, 16'h0000, 1'b1, 0},
    '{CMD_SPEED, 16'd1000, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'd999,  1'b1, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'd998,  1'b1, WANT_MODEL},
    '{CMD_SPEED, 16'd20000, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'hFFFF, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'd50000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'd100,  1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'hFFFF, 1'b1, WANT_MODEL},
    '{CMD_SPEED, 16'h0000, 16'h0000, 1'b0, WANT_MODEL},
    '{CMD_BEAM,  16'h0000, 16'd10,   1'b0, WANT_MODEL},
    '{CMD_SPEED, 16'd30000, 16'h0000, 1'b0, WANT_MODEL}, // speed change mid-scan
    '{CMD_BEAM,  16'h0000, 16'd10,   1'b1, WANT_MODEL},
    '{CMD_BEAM,  16'h1234, 16'd500,  1'b1, WANT_MODEL},
    '{CMD_SPEED, 16'd25000, 16'hFFFF, 1'b1, WANT_MODEL}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_addr_i    = '0;
  logic [15:0] cfg_data_i    = '0;

  // scan state mirror
  int                 cos_q15 [COS_TABLE_ENTRIES];
  logic [15:0]        thr_ms         = THRESHOLD_RESET;
  logic [15:0]        first_angle    = START_ANGLE_RST;
  logic [15:0]        step_angle     = ANGLE_STEP_RESET;
  logic signed [15:0] veh_speed      = '0;
  logic [15:0]        scan_angle     = '0;
  bit                 scan_fresh     = 1'b1;
  bit                 threat_latched = 1'b0;

  logic brake_q [$];
  logic brake_want;
  int   errors         = 0;
  int   words_sent     = 0;
  int   scans_seen     = 0;
  int   brakes_seen    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_cnt       = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ttc_emergency_brake dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Q15 cosine over the first quadrant, x in 1/65536 turn
  function automatic int quarter_wave_cos(input int unsigned x);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    longint          sum;
    longint          q;
    theta = (longint'(x) * PI_Q30) >> 15;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = longint'(term);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * t2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 64'sd16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return int'(q);
  endfunction

  function automatic int wrapped_cos(input int unsigned a);
    a = a & 32'hFFFF;
    if (a <= 16384) begin
      return quarter_wave_cos(a);
    end else if (a <= 32768) begin
      return -quarter_wave_cos(32768 - a);
    end else if (a <= 49152) begin
      return -quarter_wave_cos(a - 32768);
    end
    return quarter_wave_cos(65536 - a);
  endfunction

  task automatic predict_brake(input cmd_e cmd, input logic [15:0] spd,
                               input logic [15:0] rng, input logic last,
                               output bit fires, output bit brake);
    int     idx;
    longint prod;
    longint closing;
    fires = 1'b0;
    brake = 1'b0;
    if (cmd == CMD_SPEED) begin
      veh_speed = spd;
    end else begin
      if (scan_fresh) begin
        scan_angle     = first_angle;
        threat_latched = 1'b0;
        scan_fresh     = 1'b0;
      end
      idx = (int'(scan_angle) * COS_TABLE_ENTRIES) >>> 16;
      if (idx >= COS_TABLE_ENTRIES) begin
        idx = COS_TABLE_ENTRIES - 1;
      end
      prod    = longint'(veh_speed) * longint'(cos_q15[idx]);
      closing = (prod > 0) ? (prod >>> 15) : 64'sd0;
      if (rng != NO_RETURN && closing != 0 &&
          longint'(rng) * 1000 < longint'(thr_ms) * closing) begin
        threat_latched = 1'b1;
      end
      scan_angle = scan_angle + step_angle;
      if (last) begin
        fires      = 1'b1;
        brake      = threat_latched;
        scan_fresh = 1'b1;
      end
    end
  endtask

  // call at a falling edge; leaves tvalid high on return
  task automatic push_word(input cmd_e cmd, input logic [15:0] spd,
                           input logic [15:0] rng, input logic last, input int want);
    bit fires;
    bit brake;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rng, spd};
    s_axis_tlast  <= last;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_brake(cmd, spd, rng, last, fires, brake);
    if (fires) begin
      brake_q = {brake_q, ((want == WANT_MODEL) ? brake : want[0])};
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_THRESHOLD:   thr_ms = val;
      CFG_START_ANGLE: first_angle = val;
      CFG_ANGLE_STEP:  step_angle = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(input int p);
    case (p)
      0: begin
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        write_reg(CFG_ANGLE_STEP, 16'd182);
      end
      1: begin
        write_reg(CFG_THRESHOLD, 16'h0000);
        write_reg(CFG_START_ANGLE, 16'hFFFF);
        write_reg(CFG_ANGLE_STEP, 16'hFFFF);
      end
      2: begin
        write_reg(CFG_THRESHOLD, 16'($urandom_range(500, 4000)));
        write_reg(CFG_START_ANGLE, 16'($urandom));
        write_reg(CFG_ANGLE_STEP, 16'h0000);
      end
      3: begin
        write_reg(CFG_THRESHOLD, 16'($urandom));
        write_reg(CFG_START_ANGLE, 16'($urandom));
        write_reg(CFG_ANGLE_STEP, 16'($urandom_range(1, 4096)));
      end
      4: begin
        write_reg(CFG_THRESHOLD, 16'd1500);
        write_reg(CFG_START_ANGLE, 16'd16384);
        write_reg(CFG_ANGLE_STEP, 16'd64);
      end
      default: begin
        write_reg(CFG_THRESHOLD, 16'($urandom_range(200, 3000)));
        write_reg(CFG_START_ANGLE, 16'd32768);
        write_reg(CFG_ANGLE_STEP, 16'($urandom));
      end
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_speed();
    if ($urandom_range(9) < 7) begin
      return 16'($urandom_range(32767));
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_range();
    case ($urandom_range(9))
      0:          return NO_RETURN;
      1:          return 16'h0000;
      2:          return 16'hFFFE;
      3, 4, 5, 6: return 16'($urandom_range(30000));
      default:    return 16'($urandom);
    endcase
  endfunction

  // drop tvalid and hold until every brake word is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (brake_q.size() != 0);
  endtask

  task automatic run_scans(input int count, input bit pause_once);
    int n;
    int len;
    int pick;
    bit paused;
    n      = 0;
    paused = 1'b0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_word(CMD_SPEED, pick_speed(), 16'($urandom), 1'($urandom), WANT_MODEL);
        n++;
      end else if (pick < 20) begin
        push_word(cmd_e'($urandom_range(1)), 16'($urandom), 16'($urandom),
                  1'($urandom), WANT_MODEL);
        n++;
      end else begin
        len = $urandom_range(1, 12);
        for (int b = 0; b < len; b++) begin
          if ($urandom_range(9) == 0) begin
            push_word(CMD_SPEED, pick_speed(), 16'($urandom), 1'b0, WANT_MODEL);
            n++;
          end
          push_word(CMD_BEAM, 16'($urandom), pick_range(), b == len - 1, WANT_MODEL);
          n++;
        end
      end
      if (pause_once && !paused && n >= count / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (brake_q.size() == 0) begin
        errors++;
        $display("%0t: brake word %0b with none expected", $time, m_axis_tdata[0]);
      end else begin
        brake_want = brake_q.pop_front();
        scans_seen++;
        if (m_axis_tdata[0]) begin
          brakes_seen++;
        end
        if (m_axis_tdata[0] !== brake_want) begin
          errors++;
          $display("%0t: brake mismatch: expected %0b, got %0b",
                   $time, brake_want, m_axis_tdata[0]);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int guard;
    int send_pct [PHASES];
    int recv_pct [PHASES];
    send_pct = '{0, 69, 0, 22, 0, 22};
    recv_pct = '{0, 0, 69, 22, 0, 22};
    for (int i = 0; i < COS_TABLE_ENTRIES; i++) begin
      cos_q15[i] = wrapped_cos(int'((longint'(i) * 65536) / COS_TABLE_ENTRIES));
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      push_word(dir_rows[i].cmd, dir_rows[i].speed, dir_rows[i].range_mm,
                dir_rows[i].last, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clk_i);
      program_regs(p);
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      if (p == 4) begin
        hold_cnt = HOLD_CYCLES;
      end
      run_scans(PHASE_WORDS, p == PHASES - 1);
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (brake_q.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (brake_q.size() != 0) begin
      errors += brake_q.size();
      $display("%0t: %0d brake words never arrived", $time, brake_q.size());
    end

    $display("Sent %0d input words; %0d scan decisions checked, %0d of them braking.",
             words_sent, scans_seen, brakes_seen);
    $display("Register settings: reset plus %0d programmed sets, idling and back-pressure mixed.",
             PHASES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/ttc_eb_pkg.sv
sv/ttc_eb_front.sv
sv/ttc_eb_fifo.sv
sv/ttc_eb_back.sv
sv/ttc_emergency_brake.sv
bench/tb_ttc_emergency_brake.sv
